@@ rtl/btol_pkg.sv @@
// Shared types, constants and helpers for the bitmap to offset list decoder.
`timescale 1ns / 1ps
`default_nettype none
package btol_pkg;

  localparam int unsigned BYTE_BITS     = 8;
  localparam int unsigned BIT_IDX_W     = 3;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam int unsigned BASE_W        = 64;
  localparam int unsigned COUNT_W       = 32;
  localparam int unsigned OFFSET_W      = 32;
  localparam int unsigned LEN_W         = 30;
  localparam int unsigned IDS_W         = 33;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 64;
  // Byte position bits that survive into a 32-bit offset.
  localparam int unsigned POS_OFF_W     = OFFSET_W - BIT_IDX_W;

  localparam logic [BASE_W-1:0]  BASE_RST     = '0;
  localparam logic [COUNT_W-1:0] EXPECTED_RST = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] LARGEST_RST  = '0;
  localparam logic [LEN_W-1:0]   LENGTH_RST   = LEN_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ID        = 2'd0,
    REG_EXPECTED_COUNT = 2'd1,
    REG_LARGEST_OFFSET = 2'd2,
    REG_PAYLOAD_BYTES  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SIZE        = 3'd1,
    ST_NONCANON    = 3'd2,
    ST_PADDING     = 3'd3,
    ST_TOO_MANY    = 3'd4,
    ST_TOO_FEW     = 3'd5,
    ST_OVERFLOW    = 3'd6
  } status_t;

  typedef struct packed {
    logic [BASE_W-1:0]  base_id;
    logic [COUNT_W-1:0] expected_count;
    logic [COUNT_W-1:0] largest_offset;
    logic [LEN_W-1:0]   payload_bytes;
  } cfg_t;

  // One classified byte handed from the front to the back.
  typedef struct packed {
    logic [BYTE_BITS-1:0] emit;   // bits that produce an id result
    logic [BYTE_BITS-1:0] ovf;    // emitted bit whose id wraps
    logic [POS_OFF_W-1:0] pos;    // byte position, offset bits only
    logic                 close;  // byte ends the run: send status
    status_t              code;   // status of the run when close is set
  } work_t;

  // Keep the highest-priority (lowest nonzero) error code.
  function automatic status_t note_error(status_t cur, status_t code);
    status_t res;
    res = cur;
    if (cur == ST_OK || code < cur) begin
      res = code;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/btol_ifs.sv @@
// Valid/ready channel interfaces for payload bytes and decoded results.
`timescale 1ns / 1ps
`default_nettype none
interface btol_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface btol_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [63:0] id_value;
  logic [31:0] offset_value;
  logic [2:0]  status_code;
  logic        last_of_run;

  modport source (output valid, output result_kind, output id_value, output offset_value,
                  output status_code, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input id_value, input offset_value,
                  input status_code, input last_of_run, output ready);
endinterface
`default_nettype wire

@@ rtl/btol_queue.sv @@
// Small register queue of classified bytes between front and back.
`timescale 1ns / 1ps
`default_nettype none
module btol_queue #(
  parameter int unsigned DEPTH = btol_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire btol_pkg::work_t push_data,
  input  wire logic            pop,
  output btol_pkg::work_t      pop_data,
  output logic                 full,
  output logic                 empty
);
  import btol_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  work_t             slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return n;
  endfunction

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/btol_front.sv @@
// Front end: accept payload bytes, run the run checks, classify set bits.
`timescale 1ns / 1ps
`default_nettype none
module btol_front (
  input  wire logic       clk,
  input  wire logic       rst,
  btol_in_if.sink         payload,
  input  wire btol_pkg::cfg_t cfg,
  input  wire logic       q_full,
  output logic            push,
  output btol_pkg::work_t push_data
);
  import btol_pkg::*;

  logic [LEN_W-1:0] pos;
  logic [IDS_W-1:0] ids_found;
  status_t          first_error;

  logic                 accept;
  logic                 first_byte;
  logic                 last_byte;
  logic                 size_err;
  logic                 noncanon_err;
  logic                 pad_err;
  logic [BIT_IDX_W-1:0] used_bits;
  logic [BYTE_BITS-1:0] pad_mask;
  logic [COUNT_W:0]     len_need;
  logic [IDS_W-1:0]     rem_wide;
  logic [3:0]           rem_c;
  logic                 base_hi_ones;
  logic [OFFSET_W-1:0]  thr;
  logic                 hi_gt;
  logic                 hi_eq;
  logic [BYTE_BITS-1:0] ovf;
  logic [BYTE_BITS-1:0] emit;
  logic [BYTE_BITS-1:0] ovf_emit;
  logic                 seen_ovf;
  logic [3:0]           set_cnt;
  logic [3:0]           cnt_ok;
  logic                 active;
  logic                 too_many;
  logic [IDS_W-1:0]     ids_new;
  status_t              fe1;
  status_t              fe2;
  status_t              fe3;
  status_t              fe4;

  assign payload.ready = !q_full;
  assign accept        = payload.valid && !q_full;

  assign first_byte   = (pos == '0);
  assign last_byte    = ({1'b0, pos} + (LEN_W + 1)'(1)) >= {1'b0, cfg.payload_bytes};
  assign len_need     = {1'b0, cfg.largest_offset} + (COUNT_W + 1)'(BYTE_BITS);
  assign size_err     = cfg.payload_bytes != len_need[COUNT_W:BIT_IDX_W];
  assign noncanon_err = {4'b0, cfg.payload_bytes} >= {cfg.expected_count, 2'b00};
  assign used_bits    = cfg.largest_offset[BIT_IDX_W-1:0] + BIT_IDX_W'(1);
  assign pad_mask     = 8'hFF << used_bits;
  assign pad_err      = (used_bits != '0) && ((payload.data_byte & pad_mask) != '0);

  // Ids still allowed in this run, clamped to one byte's worth.
  assign rem_wide = {1'b0, cfg.expected_count} - ids_found;
  always_comb begin
    if (ids_found >= {1'b0, cfg.expected_count}) begin
      rem_c = '0;
    end else if (rem_wide >= IDS_W'(BYTE_BITS)) begin
      rem_c = 4'(BYTE_BITS);
    end else begin
      rem_c = rem_wide[3:0];
    end
  end

  // base + off wraps only if base's upper half is all ones and off > ~base.
  assign base_hi_ones = &cfg.base_id[BASE_W-1:OFFSET_W];
  assign thr          = ~cfg.base_id[OFFSET_W-1:0];
  assign hi_gt        = pos[POS_OFF_W-1:0] > thr[OFFSET_W-1:BIT_IDX_W];
  assign hi_eq        = pos[POS_OFF_W-1:0] == thr[OFFSET_W-1:BIT_IDX_W];

  always_comb begin
    for (int k = 0; k < BYTE_BITS; k++) begin
      ovf[k] = base_hi_ones &&
               (hi_gt || (hi_eq && (BIT_IDX_W'(k) > thr[BIT_IDX_W-1:0])));
    end
  end

  always_comb begin
    fe1 = first_error;
    if (first_byte) begin
      if (size_err) begin
        fe1 = note_error(fe1, ST_SIZE);
      end else if (noncanon_err) begin
        fe1 = note_error(fe1, ST_NONCANON);
      end
    end
    fe2 = fe1;
    if (last_byte && fe1 != ST_SIZE && fe1 != ST_NONCANON && pad_err) begin
      fe2 = note_error(fe1, ST_PADDING);
    end
    active   = (fe2 == ST_OK) || (fe2 > ST_TOO_MANY);
    set_cnt  = '0;
    cnt_ok   = '0;
    emit     = '0;
    ovf_emit = '0;
    seen_ovf = 1'b0;
    for (int k = 0; k < BYTE_BITS; k++) begin
      if (payload.data_byte[k]) begin
        set_cnt = set_cnt + 4'd1;
        if (active && set_cnt <= rem_c) begin
          cnt_ok = cnt_ok + 4'd1;
          if (fe2 == ST_OK && !seen_ovf) begin
            emit[k] = 1'b1;
            if (ovf[k]) begin
              ovf_emit[k] = 1'b1;
              seen_ovf    = 1'b1;
            end
          end
        end
      end
    end
    too_many = active && (set_cnt > rem_c);
    fe3 = fe2;
    if (seen_ovf) begin
      fe3 = note_error(fe3, ST_OVERFLOW);
    end
    if (too_many) begin
      fe3 = note_error(fe3, ST_TOO_MANY);
    end
    ids_new = ids_found + IDS_W'(cnt_ok);
    fe4 = fe3;
    if (last_byte && (fe3 == ST_OK || fe3 > ST_TOO_MANY) &&
        ids_new < {1'b0, cfg.expected_count}) begin
      fe4 = note_error(fe3, ST_TOO_FEW);
    end
  end

  assign push            = accept && ((emit != '0) || last_byte);
  assign push_data.emit  = emit;
  assign push_data.ovf   = ovf_emit;
  assign push_data.pos   = pos[POS_OFF_W-1:0];
  assign push_data.close = last_byte;
  assign push_data.code  = fe4;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      ids_found   <= '0;
      first_error <= ST_OK;
    end else if (accept) begin
      if (last_byte) begin
        pos         <= '0;
        ids_found   <= '0;
        first_error <= ST_OK;
      end else begin
        pos         <= pos + LEN_W'(1);
        ids_found   <= ids_new;
        first_error <= fe3;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/btol_back.sv @@
// Back end: expand classified bytes into id and status results, one per cycle while the result port is ready.
`timescale 1ns / 1ps
`default_nettype none
module btol_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [63:0] base_id,
  input  wire btol_pkg::work_t q_data,
  input  wire logic       q_empty,
  output logic            pop,
  btol_out_if.source      result
);
  import btol_pkg::*;

  work_t                cur;
  logic                 cur_valid;
  logic                 out_valid;
  logic                 advance;
  logic                 step;
  logic                 has_bit;
  logic                 finishing;
  logic [BIT_IDX_W-1:0] lo_k;
  logic [BYTE_BITS-1:0] rest;
  logic [OFFSET_W-1:0]  off;

  logic                 kind_q;
  logic [BASE_W-1:0]    id_q;
  logic [OFFSET_W-1:0]  off_q;
  status_t              code_q;
  logic                 last_q;

  always_comb begin
    lo_k = '0;
    for (int k = BYTE_BITS - 1; k >= 0; k--) begin
      if (cur.emit[k]) begin
        lo_k = BIT_IDX_W'(k);
      end
    end
  end

  assign has_bit   = cur.emit != '0;
  assign rest      = cur.emit & (cur.emit - BYTE_BITS'(1));
  assign finishing = has_bit ? ((rest == '0) && !cur.close) : 1'b1;
  assign advance   = !out_valid || result.ready;
  assign step      = advance && cur_valid;
  assign pop       = !q_empty && (!cur_valid || (step && finishing));
  assign off       = {cur.pos, lo_k};

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (step && finishing) begin
        cur_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end else if (step && has_bit) begin
      cur.emit <= rest;
    end
    if (step) begin
      kind_q <= !has_bit;
      last_q <= !has_bit;
      if (has_bit) begin
        id_q   <= base_id + {{(BASE_W - OFFSET_W){1'b0}}, off};
        off_q  <= off;
        code_q <= cur.ovf[lo_k] ? ST_OVERFLOW : ST_OK;
      end else begin
        id_q   <= '0;
        off_q  <= '0;
        code_q <= cur.code;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.result_kind  = kind_q;
  assign result.id_value     = id_q;
  assign result.offset_value = off_q;
  assign result.status_code  = code_q;
  assign result.last_of_run  = last_q;

endmodule
`default_nettype wire

@@ rtl/bitmap_to_offset_list_decoder.sv @@
// Top level of the bitmap to offset list decoder: config registers, front, queue, back.
`timescale 1ns / 1ps
`default_nettype none
// A byte passes a queue slot and the back's byte register before the result registers.
// Throughput: one payload byte per cycle is accepted while the queue has room;
//   the result port drains one word per cycle while ready, and a byte yields up to
//   nine words (one per id plus the status word on the closing byte).
// Reset: synchronous, active high; clears run state, queue and output valid and
//   loads the register defaults (base 0, count 1, largest offset 0, length 1).
module bitmap_to_offset_list_decoder #(
  parameter int unsigned QUEUE_DEPTH = btol_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  btol_in_if.sink                              payload,
  btol_out_if.source                           result,
  input  wire logic                            wr_en,
  input  wire logic [btol_pkg::CFG_IDX_W-1:0]  wr_index,
  input  wire logic [btol_pkg::CFG_DATA_W-1:0] wr_data
);
  import btol_pkg::*;

  cfg_t  cfg;
  work_t push_data;
  work_t q_data;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;

  // Config registers, read live: user writes only while the decoder is idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_id        <= BASE_RST;
      cfg.expected_count <= EXPECTED_RST;
      cfg.largest_offset <= LARGEST_RST;
      cfg.payload_bytes  <= LENGTH_RST;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_BASE_ID:        cfg.base_id        <= wr_data;
        REG_EXPECTED_COUNT: cfg.expected_count <= wr_data[COUNT_W-1:0];
        REG_LARGEST_OFFSET: cfg.largest_offset <= wr_data[COUNT_W-1:0];
        REG_PAYLOAD_BYTES:  cfg.payload_bytes  <= wr_data[LEN_W-1:0];
      endcase
    end
  end

  // Front: a byte per cycle unless the queue is full; run checks and which bits yield ids.
  btol_front u_front (
    .clk       (clk),
    .rst       (rst),
    .payload   (payload),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Hold classified bytes so the front keeps going while the back drains ids.
  btol_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: walk each byte's id bits lowest first, then the status word if it closes the run.
  btol_back u_back (
    .clk     (clk),
    .rst     (rst),
    .base_id (cfg.base_id),
    .q_data  (q_data),
    .q_empty (q_empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb_bitmap_to_offset_list_decoder.sv @@
// Testbench for the bitmap to offset list decoder: id predictor, drivers and result checks.
`timescale 1ns / 1ps
module tb_bitmap_to_offset_list_decoder;
  import btol_pkg::*;

  // Stop the run here if the result stream hangs.
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One result word as seen on the output channel.
  typedef struct packed {
    logic        kind;
    logic [63:0] id;
    logic [31:0] off;
    status_t     code;
    logic        closes;
  } result_word_t;

  // Tracks the decoder's run state and the ids and status words it must produce.
  class decoded_id_tracker;
    logic [63:0]  base_id;
    logic [31:0]  want_count;
    logic [31:0]  top_offset;
    logic [29:0]  run_length;
    logic [29:0]  pos;
    logic [32:0]  seen;
    status_t      first_err;
    result_word_t expected_words[$];
    int unsigned  mismatches;

    function new();
      base_id    = '0;
      want_count = 32'd1;
      top_offset = '0;
      run_length = 30'd1;
      pos        = '0;
      seen       = '0;
      first_err  = ST_OK;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [63:0] v);
      case (idx)
        REG_BASE_ID:        base_id    = v;
        REG_EXPECTED_COUNT: want_count = v[31:0];
        REG_LARGEST_OFFSET: top_offset = v[31:0];
        REG_PAYLOAD_BYTES:  run_length = v[29:0];
        default: ;
      endcase
    endfunction

    function void raise(status_t code);
      if (first_err == ST_OK || code < first_err) begin
        first_err = code;
      end
    endfunction

    function void take_byte(logic [7:0] b);
      logic         closing;
      logic [31:0]  used;
      logic [7:0]   pad;
      logic [31:0]  off;
      logic [64:0]  sum;
      logic         halt;
      int           k;
      result_word_t w;
      closing = ({1'b0, pos} + 31'd1) >= {1'b0, run_length};
      if (pos == '0) begin
        if ({34'd0, run_length} != (({32'd0, top_offset} + 64'd8) >> 3)) begin
          raise(ST_SIZE);
        end else if ({34'd0, run_length} >= {30'd0, want_count, 2'b00}) begin
          raise(ST_NONCANON);
        end
      end
      if (closing && first_err != ST_SIZE && first_err != ST_NONCANON) begin
        used = (top_offset + 32'd1) & 32'd7;
        if (used != 32'd0) begin
          pad = 8'hFF << used;
          if ((b & pad) != 8'd0) begin
            raise(ST_PADDING);
          end
        end
      end
      if (first_err == ST_OK || first_err > ST_TOO_MANY) begin
        halt = 1'b0;
        for (k = 0; k < 8; k++) begin
          if (!halt && b[k]) begin
            if (seen >= {1'b0, want_count}) begin
              raise(ST_TOO_MANY);
              halt = 1'b1;
            end else begin
              seen = seen + 33'd1;
              // Keep counting bits after an overflow, but emit nothing more.
              if (first_err == ST_OK) begin
                off = {pos[28:0], k[2:0]};
                sum = {1'b0, base_id} + {33'd0, off};
                if (sum[64]) begin
                  raise(ST_OVERFLOW);
                end
                w.kind   = 1'b0;
                w.id     = sum[63:0];
                w.off    = off;
                w.code   = sum[64] ? ST_OVERFLOW : ST_OK;
                w.closes = 1'b0;
                expected_words.insert(expected_words.size(), w);
              end
            end
          end
        end
      end
      if (closing) begin
        if ((first_err == ST_OK || first_err > ST_TOO_MANY) && seen < {1'b0, want_count}) begin
          raise(ST_TOO_FEW);
        end
        w.kind   = 1'b1;
        w.id     = '0;
        w.off    = '0;
        w.code   = first_err;
        w.closes = 1'b1;
        expected_words.insert(expected_words.size(), w);
        pos       = '0;
        seen      = '0;
        first_err = ST_OK;
      end else begin
        pos = pos + 30'd1;
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
    endfunction

    function void match_word(result_word_t got);
      result_word_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word kind %0d id %h offset %h status %0d last %0d",
                 $time, got.kind, got.id, got.off, got.code, got.closes);
        return;
      end
      want = expected_words.pop_front();
      compare_field("result_kind", 64'(want.kind), 64'(got.kind));
      compare_field("id_value", want.id, got.id);
      compare_field("offset_value", 64'(want.off), 64'(got.off));
      compare_field("status_code", 64'(want.code), 64'(got.code));
      compare_field("last_of_run", 64'(want.closes), 64'(got.closes));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [63:0] wr_data;

  btol_in_if  bytes_in();
  btol_out_if ids_out();

  bitmap_to_offset_list_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .payload  (bytes_in),
    .result   (ids_out),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  decoded_id_tracker tracker = new();
  result_word_t      out_word;
  int unsigned       cycle_count = 0;
  int unsigned       bytes_sent  = 0;
  bit                calm        = 1'b0;   // high: neither side idles

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Drop ready about 13 times in a hundred, except during the calm stretch.
  always @(posedge clk) begin
    ids_out.ready <= calm || ($urandom_range(99) >= 13);
  end

  // Check every accepted result word against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && ids_out.valid && ids_out.ready) begin
      out_word.kind   = ids_out.result_kind;
      out_word.id     = ids_out.id_value;
      out_word.off    = ids_out.offset_value;
      out_word.code   = status_t'(ids_out.status_code);
      out_word.closes = ids_out.last_of_run;
      tracker.match_word(out_word);
    end
  end

  // Offer one payload byte, with a random idle gap ahead of it, and hold it until
  // it is taken. The prediction is made at the accepting edge.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 13) begin
      bytes_in.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_in.valid     <= 1'b1;
    bytes_in.data_byte <= b;
    @(posedge clk);
    while (!bytes_in.ready) @(posedge clk);
    tracker.take_byte(b);
    bytes_sent++;
  endtask

  // Hold off the sender until every expected word has arrived, then give the
  // pipeline time to drain bytes that yield no word.
  task automatic settle();
    bytes_in.valid <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers, one per cycle, in index order.
  task automatic load_config(input logic [63:0] base, input logic [31:0] count,
                             input logic [31:0] top, input logic [29:0] len);
    logic [63:0] vals [4];
    int          i;
    vals[0] = base;
    vals[1] = {32'd0, count};
    vals[2] = {32'd0, top};
    vals[3] = {34'd0, len};
    for (i = 0; i < 4; i++) begin
      wr_en    <= 1'b1;
      wr_index <= cfg_reg_t'(i);
      wr_data  <= vals[i];
      @(posedge clk);
      tracker.set_reg(cfg_reg_t'(i), vals[i]);
    end
    wr_en <= 1'b0;
  endtask

  // Configure a run while idle, then stream its bytes, lowest byte of body first.
  task automatic play(input logic [63:0] base, input logic [31:0] count,
                      input logic [31:0] top, input logic [29:0] len,
                      input logic [127:0] body, input int unsigned n);
    int unsigned i;
    settle();
    load_config(base, count, top, len);
    for (i = 0; i < n; i++) begin
      send_byte(body[8*i +: 8]);
    end
  endtask

  // One random run: mostly well-formed payloads, the rest broken on purpose.
  task automatic random_run();
    int unsigned  nbytes;
    int unsigned  flavor;
    int unsigned  style;
    int unsigned  used;
    int unsigned  pop;
    int unsigned  i;
    logic [31:0]  top;
    logic [31:0]  count;
    logic [63:0]  base;
    logic [7:0]   b;
    logic [7:0]   pad_mask;
    logic [127:0] body;
    // Keep most payloads short; a few go up to sixteen bytes.
    nbytes = ($urandom_range(9) == 0) ? $urandom_range(16, 5) : $urandom_range(4, 1);
    top    = 8 * (nbytes - 1) + $urandom_range(7);
    style  = $urandom_range(2);
    body   = '0;
    for (i = 0; i < nbytes; i++) begin
      case (style)
        0: b = 8'($urandom);
        1: b = $urandom_range(1) ? (8'd1 << $urandom_range(7)) : 8'd0;
        default: b = 8'($urandom | $urandom);
      endcase
      body[8*i +: 8] = b;
    end
    // Clear the padding bits above the largest offset.
    used = (top + 1) % 8;
    if (used != 0) begin
      pad_mask = 8'hFF << used;
      body[8*(nbytes-1) +: 8] = body[8*(nbytes-1) +: 8] & ~pad_mask;
    end
    if (body == '0) begin
      body[0] = 1'b1;
    end
    flavor = $urandom_range(99);
    if (flavor >= 60 && flavor < 70 && used != 0) begin
      body[8*(nbytes-1) + $urandom_range(7, used)] = 1'b1;
    end
    pop   = $countones(body);
    count = pop;
    if (flavor >= 70 && flavor < 77) begin
      count = pop + $urandom_range(3, 1);
    end else if (flavor >= 77 && flavor < 84) begin
      count = pop - 1;
    end else if (flavor >= 84 && flavor < 90) begin
      top = $urandom_range(1) ? top + 8 * $urandom_range(3, 1) : $urandom;
    end else if (flavor >= 90 && flavor < 95) begin
      count = $urandom_range(nbytes / 4, 0);
    end else if (flavor >= 95) begin
      count = $urandom;
    end
    case ($urandom_range(3))
      0: base = 64'($urandom_range(255));
      1: base = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(8 * nbytes);
      default: base = {$urandom, $urandom};
    endcase
    play(base, count, top, nbytes[29:0], body, nbytes);
  endtask

  initial begin
    int unsigned run_idx;
    int unsigned random_start;
    rst                <= 1'b1;
    wr_en              <= 1'b0;
    wr_index           <= REG_BASE_ID;
    wr_data            <= '0;
    bytes_in.valid     <= 1'b0;
    bytes_in.data_byte <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: one byte, offset zero set, a single id and an ok status.
    send_byte(8'h01);
    // Every bit of a single byte set: eight ids then the status word.
    play(64'd0, 32'd8, 32'd7, 30'd1, 128'hFF, 1);
    // Largest offset and count at their maximum with a one byte payload: size error.
    play(64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 30'd1, 128'hFF, 1);
    // Count of zero fails the canonical check.
    play(64'd0, 32'd0, 32'd15, 30'd2, 128'h8003, 2);
    // Padding bit set in the last byte; ids of the first byte still stream out.
    play(64'd100, 32'd3, 32'd10, 30'd2, 128'h0C05, 2);
    // Second set bit exceeds a count of one.
    play(64'd0, 32'd1, 32'd15, 30'd2, 128'h1001, 2);
    // Fewer set bits than the count.
    play(64'd0, 32'd3, 32'd7, 30'd1, 128'h81, 1);
    // Base near the top: the fourth id wraps and is flagged.
    play(64'hFFFF_FFFF_FFFF_FFFD, 32'd4, 32'd7, 30'd1, 128'h0F, 1);
    // Overflow outranked by too few ids.
    play(64'hFFFF_FFFF_FFFF_FFFF, 32'd8, 32'd15, 30'd2, 128'h0003, 2);
    // Length of zero acts as one byte and fails the size check.
    play(64'd0, 32'd1, 32'd0, 30'd0, 128'h01, 1);
    // Longest payload that matches the largest offset; shrink the length while
    // idle so the next byte closes the run.
    play(64'h5555_AAAA_0F0F_F0F0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 30'h2000_0000, 128'h3CA5, 2);
    settle();
    load_config(64'h5555_AAAA_0F0F_F0F0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 30'd3);
    send_byte(8'h81);
    // Length register all ones: size error, closed the same way.
    play(64'd0, 32'd1, 32'd0, 30'h3FFF_FFFF, 128'hFF, 1);
    settle();
    load_config(64'd0, 32'd1, 32'd0, 30'd2);
    send_byte(8'h7E);

    // Random runs, with a calm stretch in the middle where nobody idles.
    run_idx      = 0;
    random_start = bytes_sent;
    while (bytes_sent < random_start + 400) begin
      calm = (run_idx >= 40 && run_idx < 70);
      random_run();
      run_idx++;
    end
    calm = 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/btol_pkg.sv
rtl/btol_ifs.sv
rtl/btol_queue.sv
rtl/btol_front.sv
rtl/btol_back.sv
rtl/bitmap_to_offset_list_decoder.sv
tb/sv/tb_bitmap_to_offset_list_decoder.sv
